/* rtl/blas_pkg.sv */
package blas_pkg;

    // Table geometry
    localparam int NODES    = 65536;
    localparam int LEVELS   = 16;
    localparam int AGE_BITS = 20;

    localparam int NODE_W    = $clog2(NODES);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JMP_DEPTH = NODES * LEVELS;
    localparam int JMP_AW    = $clog2(JMP_DEPTH);

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [LVL_W-1:0]    lvl_t;
    typedef logic [JMP_AW-1:0]   jaddr_t;

    localparam lvl_t LVL_TOP = lvl_t'(LEVELS - 1);

    // Request codes on func
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ins_load;   // capture insert request, write key
        logic ins_step;   // write one ancestor entry, read the next one
        logic q_load;     // capture query request, read start key and top jump
        logic q_t;        // jump target is back, read its key
        logic q_first;    // start node key is back as well
        logic q_k;        // decide the jump, read the next level
        logic publish;    // decide the last jump, load the result
        lvl_t lvl;        // level addressed this cycle
    } cmd_t;

    // Flat address of ancestor entry (node, level)
    function automatic jaddr_t slot(input node_t n, input lvl_t l);
        slot = jaddr_t'(jaddr_t'(n) * jaddr_t'(LEVELS) + jaddr_t'(l));
    endfunction

endpackage

/* rtl/blas_ram.sv */
module blas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/blas_ctrl.sv */
module blas_ctrl
    import blas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_func,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_QT,
        S_QK
    } state_t;

    state_t state_reg, state_next;
    lvl_t   lvl_reg, lvl_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        cmd        = '0;
        cmd.lvl    = lvl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_QUERY)
                    begin
                        cmd.q_load = 1'b1;
                        cmd.lvl    = LVL_TOP;
                        lvl_next   = LVL_TOP;
                        state_next = S_QT;
                    end
                    else
                    begin
                        cmd.ins_load = 1'b1;
                        lvl_next     = '0;
                        state_next   = S_INS;
                    end
                end
            end
            S_INS:
            begin
                cmd.ins_step = 1'b1;
                if (lvl_reg == LVL_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + lvl_t'(1);
                end
            end
            S_QT:
            begin
                cmd.q_t     = 1'b1;
                cmd.q_first = (lvl_reg == LVL_TOP);
                state_next  = S_QK;
            end
            S_QK:
            begin
                if (lvl_reg == '0)
                begin
                    // hold the last decision until the result register frees up
                    if (out_free)
                    begin
                        cmd.publish = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmd.q_k    = 1'b1;
                    cmd.lvl    = lvl_reg - lvl_t'(1);
                    lvl_next   = lvl_reg - lvl_t'(1);
                    state_next = S_QT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on publish, drop when taken
    assign out_valid_next = cmd.publish || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while still held");

    a_rose_from_qk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_QK))
        else $error("result appeared outside the final query step");

    a_qt_to_qk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QT |=> state_reg == S_QK)
        else $error("key read step not followed by decision step");

    a_ins_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && lvl_reg == LVL_TOP) |=> state_reg == S_IDLE)
        else $error("insert did not finish after the top level");
`endif

endmodule

/* rtl/blas_dp.sv */
module blas_dp
    import blas_pkg::*;
(
    input  logic  clk,
    input  cmd_t  cmd,
    input  node_t node_index,
    input  node_t parent_index,
    input  age_t  node_age,
    input  age_t  max_age,
    output node_t found_node,
    output age_t  found_age
);

    node_t  node_reg, parent_reg, p_reg;
    logic   byp_reg;
    node_t  cur_reg, t_reg;
    age_t   age_reg, limit_reg;
    node_t  found_node_reg;
    age_t   found_age_reg;

    node_t  p_cur, cur_n;
    age_t   age_n;
    logic   take;

    logic   jmp_wr_en, jmp_rd_en;
    jaddr_t jmp_wr_addr, jmp_rd_addr;
    node_t  jmp_rd_data;
    logic   key_wr_en, key_rd_en;
    node_t  key_rd_addr;
    age_t   key_rd_data;

    // Insert: parent for this level, bypassing a read of the entry just written
    always_comb
    begin
        if (cmd.lvl == '0)
        begin
            p_cur = parent_reg;
        end
        else if (byp_reg)
        begin
            p_cur = p_reg;
        end
        else
        begin
            p_cur = jmp_rd_data;
        end
    end

    // Query: take the jump when the target key is within the limit
    assign take  = (key_rd_data <= limit_reg);
    assign cur_n = take ? t_reg : cur_reg;
    assign age_n = take ? key_rd_data : age_reg;

    // Ancestor table ports
    assign jmp_wr_en   = cmd.ins_step;
    assign jmp_wr_addr = slot(node_reg, cmd.lvl);
    assign jmp_rd_en   = cmd.ins_step || cmd.q_load || cmd.q_k;

    always_comb
    begin
        if (cmd.q_load)
        begin
            jmp_rd_addr = slot(node_index, cmd.lvl);
        end
        else if (cmd.q_k)
        begin
            jmp_rd_addr = slot(cur_n, cmd.lvl);
        end
        else
        begin
            jmp_rd_addr = slot(p_cur, cmd.lvl);
        end
    end

    // Key table ports
    assign key_wr_en   = cmd.ins_load;
    assign key_rd_en   = cmd.q_load || cmd.q_t;
    assign key_rd_addr = cmd.q_load ? node_index : jmp_rd_data;

    blas_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JMP_DEPTH)
    ) u_jump_ram (
        .clk     (clk),
        .wr_en   (jmp_wr_en),
        .wr_addr (jmp_wr_addr),
        .wr_data (p_cur),
        .rd_en   (jmp_rd_en),
        .rd_addr (jmp_rd_addr),
        .rd_data (jmp_rd_data)
    );

    blas_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (NODES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (node_index),
        .wr_data (node_age),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.ins_load)
        begin
            node_reg   <= node_index;
            parent_reg <= parent_index;
        end
        if (cmd.ins_step)
        begin
            p_reg   <= p_cur;
            byp_reg <= (p_cur == node_reg);
        end
        if (cmd.q_load)
        begin
            cur_reg   <= node_index;
            limit_reg <= max_age;
        end
        if (cmd.q_t)
        begin
            t_reg <= jmp_rd_data;
        end
        if (cmd.q_first)
        begin
            age_reg <= key_rd_data;
        end
        if (cmd.q_k || cmd.publish)
        begin
            cur_reg <= cur_n;
            age_reg <= age_n;
        end
        if (cmd.publish)
        begin
            found_node_reg <= cur_n;
            found_age_reg  <= age_n;
        end
    end

    assign found_node = found_node_reg;
    assign found_age  = found_age_reg;

endmodule

/* rtl/binary_lifting_ancestor_search.sv */
// Ancestor table with age-limited search over binary-lifting jumps.
// Input channel: in_valid / in_stall with func, node_index, parent_index,
// node_age and max_age. func 0 inserts a node (its parent must already be in
// the table; a root names itself as parent) and gives no result. func 1 runs
// a query from node_index and gives one result on the output channel.
// Output channel: out_valid / out_stall with found_node and found_age.
// An insert captures the request and writes the key, then steps through the
// levels, each step writing an ancestor entry and reading the next.
// A query starts from the top level and works down; each level needs
// a jump read and then a key read of the target, both from single-read-port
// tables, and the next level's address depends on that decision.
// in_stall is high from acceptance until the request finishes.
// The result register frees the block: a new request is taken while a result
// waits. If a second query finishes while the first result is still stalled,
// it holds its final step until the result is taken.
// Reset clears the controller and the output valid; the tables are not
// cleared, and querying a node never inserted gives undefined data.
module binary_lifting_ancestor_search
    import blas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  func,
    input  node_t node_index,
    input  node_t parent_index,
    input  age_t  node_age,
    input  age_t  max_age,
    output logic  out_valid,
    input  logic  out_stall,
    output node_t found_node,
    output age_t  found_age
);

    cmd_t cmd;

    blas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (func),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    blas_dp u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .node_index   (node_index),
        .parent_index (parent_index),
        .node_age     (node_age),
        .max_age      (max_age),
        .found_node   (found_node),
        .found_age    (found_age)
    );

endmodule

/* tb/testbench.sv */
module testbench
    import blas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Drain-side stall behaviors, switched in random segments
    typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HALF, DRAIN_HEAVY} drain_mode_t;

    typedef struct {
        node_t node;
        age_t  age;
    } ancestor_t;

    logic  clk;
    logic  rst_n        = 1'b0;
    logic  in_valid     = 1'b0;
    logic  in_stall;
    logic  func         = FUNC_INSERT;
    node_t node_index   = '0;
    node_t parent_index = '0;
    age_t  node_age     = '0;
    age_t  max_age      = '0;
    logic  out_valid;
    logic  out_stall    = 1'b0;
    node_t found_node;
    age_t  found_age;

    // Mirror of the ancestor rows (node * LEVELS + level) and the stored ages
    node_t     anc_tab [int];
    age_t      age_tab [int];
    node_t     placed_nodes [$];
    ancestor_t pending_answers [$];

    int mismatches    = 0;
    int burst_left    = 0;
    bit sender_idles  = 1'b1;
    int hold_request  = 0;

    binary_lifting_ancestor_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .node_index   (node_index),
        .parent_index (parent_index),
        .node_age     (node_age),
        .max_age      (max_age),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found_node   (found_node),
        .found_age    (found_age)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build the row of an inserted node from its parent's row
    function automatic void record_insert(input node_t n, input node_t p, input age_t a);
        node_t hop;
        hop = p;
        age_tab[int'(n)] = a;
        for (int k = 0; k < LEVELS; k++)
        begin
            anc_tab[int'(n) * LEVELS + k] = hop;
            hop = anc_tab[int'(hop) * LEVELS + k];
        end
    endfunction

    // Walk from the largest jump down, taking each jump whose target fits the limit
    function automatic ancestor_t climb(input node_t start, input age_t limit);
        ancestor_t hit;
        node_t     at;
        node_t     tgt;
        at = start;
        for (int k = LEVELS - 1; k >= 0; k--)
        begin
            tgt = anc_tab[int'(at) * LEVELS + k];
            if (age_tab[int'(tgt)] <= limit)
                at = tgt;
        end
        hit.node = at;
        hit.age  = age_tab[int'(at)];
        return hit;
    endfunction

    // Prefer recently placed nodes so that chains grow deep
    function automatic node_t pick_node();
        int sz;
        sz = placed_nodes.size();
        if (sz > 8 && $urandom_range(0, 2) != 0)
            return placed_nodes[$urandom_range(sz - 8, sz - 1)];
        return placed_nodes[$urandom_range(0, sz - 1)];
    endfunction

    // Offer one request, wait for acceptance, predict, then maybe idle
    task automatic issue_request(input logic f, input node_t n, input node_t p,
                                 input age_t a, input age_t lim);
        int gap;
        in_valid     <= 1'b1;
        func         <= f;
        node_index   <= n;
        parent_index <= p;
        node_age     <= a;
        max_age      <= lim;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        if (f == FUNC_INSERT)
        begin
            if (!age_tab.exists(int'(n)))
                placed_nodes = {placed_nodes, n};
            record_insert(n, p, a);
        end
        else
        begin
            pending_answers = {pending_answers, climb(n, lim)};
        end
        // End a burst with a random gap
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = sender_idles ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random mix of inserts and queries over a growing forest
    task automatic run_random_forest(input int count);
        node_t n;
        node_t p;
        age_t  a;
        age_t  lim;
        int    pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (placed_nodes.size() == 0 || pick < 45)
            begin
                if (placed_nodes.size() == 0 || pick < 5)
                begin
                    // new root
                    n = node_t'($urandom);
                    p = n;
                    a = ($urandom_range(0, 3) == 0) ? '1 : age_t'($urandom);
                end
                else
                begin
                    p = pick_node();
                    n = (pick < 40) ? node_t'($urandom) : pick_node();
                    if ($urandom_range(0, 4) == 0)
                        a = age_t'($urandom);
                    else
                        a = age_tab[int'(p)] - age_t'($urandom_range(0, age_tab[int'(p)] >> 2));
                end
                issue_request(FUNC_INSERT, n, p, a, age_t'($urandom));
            end
            else
            begin
                n = pick_node();
                case ($urandom_range(0, 9)) inside
                    0:       lim = '0;
                    1:       lim = '1;
                    [2:3]:   lim = age_t'($urandom);
                    default: lim = age_tab[int'(pick_node())] + age_t'($urandom_range(0, 2)) - 1'b1;
                endcase
                issue_request(FUNC_QUERY, n, node_t'($urandom), age_t'($urandom), lim);
            end
        end
    endtask

    // Extremes of indices and ages, roots, boundaries, re-insert
    task automatic test_directed();
        sender_idles = 1'b0;
        issue_request(FUNC_INSERT, 16'h0000, 16'h0000, 20'h00000, 20'hFFFFF);
        issue_request(FUNC_QUERY,  16'h0000, 16'hFFFF, 20'hFFFFF, 20'h00000);
        issue_request(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'h00000);
        issue_request(FUNC_QUERY,  16'hFFFF, 16'h0000, 20'h00000, 20'h00000);
        issue_request(FUNC_QUERY,  16'hFFFF, 16'h0000, 20'h00000, 20'hFFFFF);
        issue_request(FUNC_INSERT, 16'h8000, 16'h8000, 20'h80000, 20'h00000);
        issue_request(FUNC_INSERT, 16'h7FFF, 16'h8000, 20'h40000, 20'h00000);
        issue_request(FUNC_INSERT, 16'h5555, 16'h7FFF, 20'h20000, 20'h00000);
        issue_request(FUNC_INSERT, 16'hAAAA, 16'h5555, 20'h00001, 20'h00000);
        // query right behind the insert of its start node
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'hFFFFF);
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'h3FFFF);
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'h00000);
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'h40000);
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'h80000);
        // move a node under another root and query across the change
        issue_request(FUNC_INSERT, 16'h5555, 16'h0000, 20'h00002, 20'h00000);
        issue_request(FUNC_QUERY,  16'h5555, 16'h0000, 20'h00000, 20'hFFFFF);
        issue_request(FUNC_QUERY,  16'hAAAA, 16'h0000, 20'h00000, 20'h00001);
        issue_request(FUNC_INSERT, 16'h0001, 16'hFFFF, 20'hFFFFE, 20'h00000);
        issue_request(FUNC_QUERY,  16'h0001, 16'h0000, 20'h00000, 20'hFFFFE);
        issue_request(FUNC_QUERY,  16'h0001, 16'h0000, 20'h00000, 20'hFFFFF);
        sender_idles = 1'b1;
    endtask

    // One long chain so that many jump levels land on distinct ancestors
    task automatic test_deep_chain();
        node_t tip;
        node_t root;
        node_t n;
        age_t  tip_age;
        age_t  step;
        root    = node_t'($urandom);
        tip     = root;
        tip_age = 20'hFFFFF - age_t'($urandom_range(0, 1000));
        issue_request(FUNC_INSERT, root, root, tip_age, age_t'($urandom));
        for (int i = 0; i < 80; i++)
        begin
            n    = node_t'($urandom);
            step = age_t'($urandom_range(1, 6000));
            tip_age = (tip_age > step) ? tip_age - step : '0;
            issue_request(FUNC_INSERT, n, tip, tip_age, age_t'($urandom));
            tip = n;
            if (i % 2 == 1)
                issue_request(FUNC_QUERY, tip, node_t'($urandom), age_t'($urandom),
                              age_tab[int'(pick_node())] + age_t'($urandom_range(0, 2)) - 1'b1);
        end
    endtask

    task automatic test_random_forest();
        run_random_forest(300);
    endtask

    // Hold the drain side off while requests keep coming, filling the block
    task automatic test_pressure();
        sender_idles = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 30; i++)
            issue_request(FUNC_QUERY, pick_node(), node_t'($urandom), age_t'($urandom),
                          age_t'($urandom));
        sender_idles = 1'b1;
    endtask

    task automatic test_back_to_back();
        sender_idles = 1'b0;
        run_random_forest(60);
        sender_idles = 1'b1;
    endtask

    // Drain-side stall pattern, with long hold-offs on request
    initial
    begin
        drain_mode_t mode;
        int seg;
        int hold_left;
        mode      = DRAIN_FREE;
        seg       = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (seg == 0)
                begin
                    mode = drain_mode_t'($urandom_range(0, 3));
                    seg  = $urandom_range(5, 60);
                end
                seg--;
                case (mode)
                    DRAIN_FREE:  out_stall <= 1'b0;
                    DRAIN_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    DRAIN_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                    default:     out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest predicted ancestor
    initial
    begin
        ancestor_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result: node %h age %h", $time,
                             found_node, found_age);
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (found_node !== want.node)
                    begin
                        $display("%0t: found_node expected %h actual %h", $time,
                                 want.node, found_node);
                        mismatches++;
                    end
                    if (found_age !== want.age)
                    begin
                        $display("%0t: found_age expected %h actual %h", $time,
                                 want.age, found_age);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_deep_chain();
        test_random_forest();
        test_pressure();
        test_back_to_back();
        in_valid <= 1'b0;
        // Let the last results drain, then allow for an insert still in flight
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (2 * LEVELS + 8) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
